[hdl/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, register indexes, status codes and helpers for the
// pressure/temperature compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int unsigned DIV_STEPS = 64;

    localparam logic [19:0]        RAW_DISABLED = 20'h80000;
    localparam logic [20:0]        PRESS_OFFSET = 21'd1048576;
    localparam logic signed [32:0] FINE_OFFSET  = 33'sd128000;
    localparam logic [11:0]        PRESS_SCALE  = 12'd3125;
    localparam logic [31:0]        TEMP_ROUND   = 32'd128;
    localparam logic [63:0]        W1_BIAS      = 64'h0000_8000_0000_0000;

    typedef enum logic [2:0] {
        CFG_TEMP_CAL_A           = 3'd0,
        CFG_TEMP_CAL_B           = 3'd1,
        CFG_PRESS_CAL_ONE        = 3'd2,
        CFG_PRESS_CAL_TWO_THREE  = 3'd3,
        CFG_PRESS_CAL_FOUR_FIVE  = 3'd4,
        CFG_PRESS_CAL_SIX_SEVEN  = 3'd5,
        CFG_PRESS_CAL_EIGHT_NINE = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TEMP_OFF  = 2'd1,
        STATUS_PRESS_OFF = 2'd2,
        STATUS_ZERO_DIV  = 2'd3
    } status_t;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] fine_temperature;
        logic signed [31:0] temperature_scaled;
        logic [31:0]        pressure_q24_8;
    } out_word_t;

    typedef struct packed {
        logic        t_dis;
        logic        p_dis;
        logic [31:0] fine;
        logic [31:0] scaled;
    } side_t;

    typedef struct packed {
        side_t base;
        logic  zero_div;
        logic  neg_quot;
    } div_side_t;

    function automatic logic [31:0] sx16_32(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx16_64(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx49_64(logic [48:0] v);
        return {{15{v[48]}}, v};
    endfunction

    function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
        return $signed(x) >>> n;
    endfunction

endpackage

[hdl/ptc_div.sv]
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Divisor magnitude is below 2^31, so the remainder stays 31 bits wide.
// ----------------------------------------------------------------------------
module ptc_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [63:0]           in_num,
    input  logic [30:0]           in_den,
    input  ptc_pkg::div_side_t    in_side,
    output logic                  out_valid,
    output logic [63:0]           out_quot,
    output ptc_pkg::div_side_t    out_side
);

    localparam int unsigned N = ptc_pkg::DIV_STEPS;

    logic [N-1:0]       vld_reg;
    logic [63:0]        nq_reg   [0:N-1];
    logic [30:0]        rem_reg  [0:N-1];
    logic [30:0]        den_reg  [0:N-1];
    ptc_pkg::div_side_t side_reg [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic               src_vld;
        logic [63:0]        src_nq;
        logic [30:0]        src_rem;
        logic [30:0]        src_den;
        ptc_pkg::div_side_t src_side;
        logic [31:0]        trial;
        logic [31:0]        diff;
        logic               ge;

        if (k == 0) begin : g_first
            assign src_vld  = in_valid;
            assign src_nq   = in_num;
            assign src_rem  = '0;
            assign src_den  = in_den;
            assign src_side = in_side;
        end
        else begin : g_next
            assign src_vld  = vld_reg[k-1];
            assign src_nq   = nq_reg[k-1];
            assign src_rem  = rem_reg[k-1];
            assign src_den  = den_reg[k-1];
            assign src_side = side_reg[k-1];
        end

        // shift next dividend bit into the partial remainder
        assign trial = {src_rem, src_nq[63]};
        assign diff  = trial - {1'b0, src_den};
        assign ge    = (trial >= {1'b0, src_den});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[k]   <= {src_nq[62:0], ge};
                rem_reg[k]  <= ge ? diff[30:0] : trial[30:0];
                den_reg[k]  <= src_den;
                side_reg[k] <= src_side;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_quot  = nq_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

[hdl/pressure_temperature_compensation_unit.sv]
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_unit
// Integer compensation of raw 20-bit temperature/pressure pairs against
// calibration registers: fine temperature, scaled temperature, Q24.8 pressure.
// ----------------------------------------------------------------------------
// Pipeline: 12 front stages, 64 divider stages, 7 back stages, output register.
// Throughput: one word per cycle; the whole pipeline advances unless the
// output register holds a word that is stalled.
// Reset: valid bits cleared, calibration registers cleared to zero.
module pressure_temperature_compensation_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ptc_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ptc_pkg::out_word_t  out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    // ---------------- calibration registers ----------------
    logic [31:0] cal_ta_reg;
    logic [15:0] cal_tb_reg;
    logic [15:0] cal_p1_reg;
    logic [31:0] cal_p23_reg;
    logic [31:0] cal_p45_reg;
    logic [31:0] cal_p67_reg;
    logic [31:0] cal_p89_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_ta_reg  <= '0;
            cal_tb_reg  <= '0;
            cal_p1_reg  <= '0;
            cal_p23_reg <= '0;
            cal_p45_reg <= '0;
            cal_p67_reg <= '0;
            cal_p89_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptc_pkg::CFG_TEMP_CAL_A:           cal_ta_reg  <= cfg_data;
                ptc_pkg::CFG_TEMP_CAL_B:           cal_tb_reg  <= cfg_data[15:0];
                ptc_pkg::CFG_PRESS_CAL_ONE:        cal_p1_reg  <= cfg_data[15:0];
                ptc_pkg::CFG_PRESS_CAL_TWO_THREE:  cal_p23_reg <= cfg_data;
                ptc_pkg::CFG_PRESS_CAL_FOUR_FIVE:  cal_p45_reg <= cfg_data;
                ptc_pkg::CFG_PRESS_CAL_SIX_SEVEN:  cal_p67_reg <= cfg_data;
                ptc_pkg::CFG_PRESS_CAL_EIGHT_NINE: cal_p89_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = cal_ta_reg[15:0];
    assign t2 = cal_ta_reg[31:16];
    assign t3 = cal_tb_reg;
    assign p1 = cal_p1_reg;
    assign p2 = cal_p23_reg[15:0];
    assign p3 = cal_p23_reg[31:16];
    assign p4 = cal_p45_reg[15:0];
    assign p5 = cal_p45_reg[31:16];
    assign p6 = cal_p67_reg[15:0];
    assign p7 = cal_p67_reg[31:16];
    assign p8 = cal_p89_reg[15:0];
    assign p9 = cal_p89_reg[31:16];

    // ---------------- flow control ----------------
    logic out_valid_reg;
    logic en;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // ---------------- front stages ----------------
    logic [12:1] fv_reg;

    logic               tdis_reg [1:4];
    logic               pdis_reg [1:4];
    logic [20:0]        praw_reg [1:8];
    ptc_pkg::side_t     fside_reg [5:11];

    logic signed [17:0] s1_a_reg,   s1_a_next;
    logic signed [16:0] s1_b_reg,   s1_b_next;
    logic signed [33:0] s2_ma_reg,  s2_ma_next;
    logic signed [33:0] s2_mbb_reg, s2_mbb_next;
    logic signed [31:0] s3_v1_reg,  s3_v1_next;
    logic signed [31:0] s3_m3_reg,  s3_m3_next;
    logic signed [31:0] s3_bbs;
    logic [31:0]        s4_fine_reg, s4_fine_next;
    logic [31:0]        s5_scaled;
    logic signed [32:0] s5_d_reg,   s5_d_next;
    logic signed [65:0] s6_dd_full;
    logic [63:0]        s6_dd_reg;
    logic signed [48:0] s6_dp5_reg, s6_dp5_next;
    logic signed [48:0] s6_dp2_reg, s6_dp2_next;
    logic signed [32:0] s7_ddl;
    logic signed [48:0] s7_a6l_reg, s7_a6l_next;
    logic [31:0]        s7_a6h_reg, s7_a6h_next;
    logic signed [48:0] s7_a3l_reg, s7_a3l_next;
    logic [31:0]        s7_a3h_reg, s7_a3h_next;
    logic signed [48:0] s7_dp5_reg;
    logic signed [48:0] s7_dp2_reg;
    logic [63:0]        s8_dp5_64;
    logic [63:0]        s8_w2_reg,  s8_w2_next;
    logic [63:0]        s8_sum_reg, s8_sum_next;
    logic signed [48:0] s8_dp2_reg;
    logic [63:0]        s9_dp2_64;
    logic [63:0]        s9_w1_reg,  s9_w1_next;
    logic [63:0]        s9_num_reg, s9_num_next;
    logic [47:0]        s10_dl_reg, s10_dl_next;
    logic [31:0]        s10_dh_reg, s10_dh_next;
    logic [43:0]        s10_nl_reg, s10_nl_next;
    logic [31:0]        s10_nh_reg, s10_nh_next;
    logic [63:0]        s11_den64;
    logic [30:0]        s11_den_reg;
    logic [63:0]        s11_num_reg, s11_num_next;
    logic [63:0]        s12_num_reg, s12_num_next;
    logic [30:0]        s12_den_reg, s12_den_next;
    ptc_pkg::div_side_t s12_side_reg, s12_side_next;

    always_comb
    begin
        s1_a_next = {1'b0, in_data.raw_temperature[19:3]} - {1'b0, t1, 1'b0};
        s1_b_next = {1'b0, in_data.raw_temperature[19:4]} - {1'b0, t1};

        s2_ma_next  = s1_a_reg * t2;
        s2_mbb_next = s1_b_reg * s1_b_reg;

        s3_v1_next = ptc_pkg::asr32(s2_ma_reg[31:0], 11);
        s3_bbs     = ptc_pkg::asr32(s2_mbb_reg[31:0], 12);
        s3_m3_next = s3_bbs * t3;

        s4_fine_next = s3_v1_reg + ptc_pkg::asr32(s3_m3_reg, 14);

        s5_scaled = {s4_fine_reg[29:0], 2'b00} + s4_fine_reg + ptc_pkg::TEMP_ROUND;
        s5_d_next = {s4_fine_reg[31], s4_fine_reg} - ptc_pkg::FINE_OFFSET;

        s6_dd_full  = s5_d_reg * s5_d_reg;
        s6_dp5_next = s5_d_reg * p5;
        s6_dp2_next = s5_d_reg * p2;

        // 64-bit wrapping products split into low-word and high-word parts
        s7_ddl      = {1'b0, s6_dd_reg[31:0]};
        s7_a6l_next = s7_ddl * p6;
        s7_a6h_next = s6_dd_reg[63:32] * ptc_pkg::sx16_32(p6);
        s7_a3l_next = s7_ddl * p3;
        s7_a3h_next = s6_dd_reg[63:32] * ptc_pkg::sx16_32(p3);

        s8_dp5_64   = ptc_pkg::sx49_64(s7_dp5_reg);
        s8_w2_next  = ptc_pkg::sx49_64(s7_a6l_reg) + {s7_a6h_reg, 32'd0}
                    + (s8_dp5_64 << 17) + (ptc_pkg::sx16_64(p4) << 35);
        s8_sum_next = ptc_pkg::sx49_64(s7_a3l_reg) + {s7_a3h_reg, 32'd0};

        s9_dp2_64   = ptc_pkg::sx49_64(s8_dp2_reg);
        s9_w1_next  = ptc_pkg::asr64(s8_sum_reg, 8) + (s9_dp2_64 << 12)
                    + ptc_pkg::W1_BIAS;
        s9_num_next = ({43'd0, praw_reg[8]} << 31) - s8_w2_reg;

        s10_dl_next = s9_w1_reg[31:0] * p1;
        s10_dh_next = s9_w1_reg[63:32] * {16'd0, p1};
        s10_nl_next = s9_num_reg[31:0] * ptc_pkg::PRESS_SCALE;
        s10_nh_next = s9_num_reg[63:32] * {20'd0, ptc_pkg::PRESS_SCALE};

        s11_den64    = {16'd0, s10_dl_reg} + {s10_dh_reg, 32'd0};
        s11_num_next = {20'd0, s10_nl_reg} + {s10_nh_reg, 32'd0};

        // signed operands to magnitudes for the unsigned divider
        s12_num_next = s11_num_reg[63] ? (64'd0 - s11_num_reg) : s11_num_reg;
        s12_den_next = s11_den_reg[30] ? (31'd0 - s11_den_reg) : s11_den_reg;
        s12_side_next.base     = fside_reg[11];
        s12_side_next.zero_div = (s11_den_reg == 31'd0);
        s12_side_next.neg_quot = s11_num_reg[63] ^ s11_den_reg[30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (en)
        begin
            fv_reg <= {fv_reg[11:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdis_reg[1] <= (in_data.raw_temperature == ptc_pkg::RAW_DISABLED);
            pdis_reg[1] <= (in_data.raw_pressure == ptc_pkg::RAW_DISABLED);
            praw_reg[1] <= ptc_pkg::PRESS_OFFSET - {1'b0, in_data.raw_pressure};
            for (int i = 2; i <= 4; i++)
            begin
                tdis_reg[i] <= tdis_reg[i-1];
                pdis_reg[i] <= pdis_reg[i-1];
            end
            for (int i = 2; i <= 8; i++)
            begin
                praw_reg[i] <= praw_reg[i-1];
            end
            fside_reg[5].t_dis  <= tdis_reg[4];
            fside_reg[5].p_dis  <= pdis_reg[4];
            fside_reg[5].fine   <= s4_fine_reg;
            fside_reg[5].scaled <= s5_scaled;
            for (int i = 6; i <= 11; i++)
            begin
                fside_reg[i] <= fside_reg[i-1];
            end

            s1_a_reg     <= s1_a_next;
            s1_b_reg     <= s1_b_next;
            s2_ma_reg    <= s2_ma_next;
            s2_mbb_reg   <= s2_mbb_next;
            s3_v1_reg    <= s3_v1_next;
            s3_m3_reg    <= s3_m3_next;
            s4_fine_reg  <= s4_fine_next;
            s5_d_reg     <= s5_d_next;
            s6_dd_reg    <= s6_dd_full[63:0];
            s6_dp5_reg   <= s6_dp5_next;
            s6_dp2_reg   <= s6_dp2_next;
            s7_a6l_reg   <= s7_a6l_next;
            s7_a6h_reg   <= s7_a6h_next;
            s7_a3l_reg   <= s7_a3l_next;
            s7_a3h_reg   <= s7_a3h_next;
            s7_dp5_reg   <= s6_dp5_reg;
            s7_dp2_reg   <= s6_dp2_reg;
            s8_w2_reg    <= s8_w2_next;
            s8_sum_reg   <= s8_sum_next;
            s8_dp2_reg   <= s7_dp2_reg;
            s9_w1_reg    <= s9_w1_next;
            s9_num_reg   <= s9_num_next;
            s10_dl_reg   <= s10_dl_next;
            s10_dh_reg   <= s10_dh_next;
            s10_nl_reg   <= s10_nl_next;
            s10_nh_reg   <= s10_nh_next;
            s11_den_reg  <= s11_den64[63:33];
            s11_num_reg  <= s11_num_next;
            s12_num_reg  <= s12_num_next;
            s12_den_reg  <= s12_den_next;
            s12_side_reg <= s12_side_next;
        end
    end

    // ---------------- divider ----------------
    logic               div_valid;
    logic [63:0]        div_quot;
    ptc_pkg::div_side_t div_side;

    ptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fv_reg[12]),
        .in_num    (s12_num_reg),
        .in_den    (s12_den_reg),
        .in_side   (s12_side_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // ---------------- back stages ----------------
    logic [7:1]         bv_reg;
    ptc_pkg::div_side_t bside_reg [1:7];
    logic [63:0]        q_reg     [1:5];
    logic [63:0]        w2_reg    [3:5];

    logic [63:0]        b2_x;
    logic signed [32:0] b2_xl, b2_ql;
    logic signed [48:0] b2_yl_reg, b2_yl_next;
    logic [31:0]        b2_yh_reg, b2_yh_next;
    logic signed [48:0] b2_el_reg, b2_el_next;
    logic [31:0]        b2_eh_reg, b2_eh_next;
    logic [63:0]        b3_y_reg, b3_y_next;
    logic [63:0]        b3_e;
    logic [63:0]        b4_x;
    logic [63:0]        b4_m0_reg, b4_m0_next;
    logic [31:0]        b4_m1_reg, b4_m1_next;
    logic [31:0]        b4_m2_reg, b4_m2_next;
    logic [63:0]        b5_z;
    logic [63:0]        b5_w1_reg;
    logic [63:0]        b6_s_reg, b6_s_next;
    logic [63:0]        b7_r_reg, b7_r_next;
    ptc_pkg::out_word_t out_reg, out_next;

    always_comb
    begin
        b2_x       = ptc_pkg::asr64(q_reg[1], 13);
        b2_xl      = {1'b0, b2_x[31:0]};
        b2_ql      = {1'b0, q_reg[1][31:0]};
        b2_yl_next = b2_xl * p9;
        b2_yh_next = b2_x[63:32] * ptc_pkg::sx16_32(p9);
        b2_el_next = b2_ql * p8;
        b2_eh_next = q_reg[1][63:32] * ptc_pkg::sx16_32(p8);

        b3_y_next = ptc_pkg::sx49_64(b2_yl_reg) + {b2_yh_reg, 32'd0};
        b3_e      = ptc_pkg::sx49_64(b2_el_reg) + {b2_eh_reg, 32'd0};

        // (p9 * x) * x modulo 2^64 from 32-bit partial products
        b4_x       = ptc_pkg::asr64(q_reg[3], 13);
        b4_m0_next = b3_y_reg[31:0] * b4_x[31:0];
        b4_m1_next = b3_y_reg[31:0] * b4_x[63:32];
        b4_m2_next = b3_y_reg[63:32] * b4_x[31:0];

        b5_z = b4_m0_reg + {b4_m1_reg + b4_m2_reg, 32'd0};

        b6_s_next = q_reg[5] + b5_w1_reg + w2_reg[5];
        b7_r_next = ptc_pkg::asr64(b6_s_reg, 8) + (ptc_pkg::sx16_64(p7) << 4);

        out_next.status             = ptc_pkg::STATUS_OK;
        out_next.fine_temperature   = bside_reg[7].base.fine;
        out_next.temperature_scaled = bside_reg[7].base.scaled;
        out_next.pressure_q24_8     = '0;
        if (bside_reg[7].base.t_dis)
        begin
            out_next.status             = ptc_pkg::STATUS_TEMP_OFF;
            out_next.fine_temperature   = '0;
            out_next.temperature_scaled = '0;
        end
        else if (bside_reg[7].base.p_dis)
        begin
            out_next.status = ptc_pkg::STATUS_PRESS_OFF;
        end
        else if (bside_reg[7].zero_div)
        begin
            out_next.status = ptc_pkg::STATUS_ZERO_DIV;
        end
        else if (b7_r_reg[63])
        begin
            out_next.pressure_q24_8 = '0;
        end
        else if (b7_r_reg[62:32] != 31'd0)
        begin
            out_next.pressure_q24_8 = '1;
        end
        else
        begin
            out_next.pressure_q24_8 = b7_r_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            bv_reg        <= {bv_reg[6:1], div_valid};
            out_valid_reg <= bv_reg[7];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bside_reg[1] <= div_side;
            for (int i = 2; i <= 7; i++)
            begin
                bside_reg[i] <= bside_reg[i-1];
            end
            q_reg[1] <= div_side.neg_quot ? (64'd0 - div_quot) : div_quot;
            for (int i = 2; i <= 5; i++)
            begin
                q_reg[i] <= q_reg[i-1];
            end
            w2_reg[3] <= ptc_pkg::asr64(b3_e, 19);
            w2_reg[4] <= w2_reg[3];
            w2_reg[5] <= w2_reg[4];

            b2_yl_reg <= b2_yl_next;
            b2_yh_reg <= b2_yh_next;
            b2_el_reg <= b2_el_next;
            b2_eh_reg <= b2_eh_next;
            b3_y_reg  <= b3_y_next;
            b4_m0_reg <= b4_m0_next;
            b4_m1_reg <= b4_m1_next;
            b4_m2_reg <= b4_m2_next;
            b5_w1_reg <= ptc_pkg::asr64(b5_z, 25);
            b6_s_reg  <= b6_s_next;
            b7_r_reg  <= b7_r_next;
            out_reg   <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
